### design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared field widths, status codes and register indexes of the first-fit
// free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // payload field widths
    localparam int OFF_W  = 32;
    localparam int SIZE_W = 16;
    localparam int CNT_W  = 16;
    localparam int STAT_W = 2;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_END_OFFSET   = 8'd0,
        CFG_START_RECORD_COUNT = 8'd1
    } cfg_index_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_REUSED   = 2'd0,
        ST_APPENDED = 2'd1,
        ST_LOADED   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // reset values of the configuration registers
    localparam logic [OFF_W-1:0] END_OFFSET_RESET = 32'd25;
    localparam logic [CNT_W-1:0] LIVE_RESET       = 16'd0;

endpackage

### design/ffa_node_store.sv
// ----------------------------------------------------------------------------
// ffa_node_store
// Node table: one entry per slot holding block offset, block size and link.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_node_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int LINK_W = 7
) (
    input  logic                                            aclk,
    input  logic                                            rd_en,
    input  logic [ADDR_W-1:0]                               rd_addr,
    output logic [ffa_pkg::OFF_W+ffa_pkg::SIZE_W+LINK_W-1:0] rd_data,
    input  logic                                            wr_en,
    input  logic [ADDR_W-1:0]                               wr_addr,
    input  logic [ffa_pkg::OFF_W+ffa_pkg::SIZE_W+LINK_W-1:0] wr_data
);

    localparam int ENT_W = ffa_pkg::OFF_W + ffa_pkg::SIZE_W + LINK_W;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/first_fit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// Free-list allocator: loads freed blocks at the list tail and places
// records first-fit, falling back to the end offset.
// ----------------------------------------------------------------------------
// Load: a full table goes straight to the result; else a slot comes from the fill
// counter or the pool chain, the old tail is linked and the new node written.
// Allocate walks the list entry by entry, bound by the single node-table read port.
// One item at a time: the next item is taken back in idle, after its result beat loads;
// a beat still waiting holds back the next. Reset sets pointers, counters and
// output valid; the node table is not cleared (slots: fill counter, free chain).
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core #(
    parameter int FREE_SLOTS   = 64,
    parameter int PREFIX_BYTES = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input item: [31:0] free_offset, [47:32] free_size, [63:48] request_size
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,
    // [0] mode
    input  logic                            s_tuser,
    // result: [31:0] place_offset, [47:32] slot_size, [63:48] pad_bytes,
    // [79:64] record_count, [95:80] removed_count, [96] list_empty
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [103:0]                    m_tdata,
    // [1:0] status
    output logic [1:0]                      m_tuser,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int OFF_W  = ffa_pkg::OFF_W;
    localparam int SIZE_W = ffa_pkg::SIZE_W;
    localparam int CNT_W  = ffa_pkg::CNT_W;
    localparam int IW     = $clog2(FREE_SLOTS);
    localparam int SW     = $clog2(FREE_SLOTS + 1);
    localparam int ENT_W  = OFF_W + SIZE_W + SW;
    localparam logic [SW-1:0]    NONE   = SW'(FREE_SLOTS);
    localparam logic [OFF_W-1:0] PREFIX = OFF_W'(PREFIX_BYTES);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_LOAD   = 11'b000_0000_0010,
        S_L_POP  = 11'b000_0000_0100,
        S_L_TAIL = 11'b000_0000_1000,
        S_L_TWR  = 11'b000_0001_0000,
        S_L_NEW  = 11'b000_0010_0000,
        S_A_STRT = 11'b000_0100_0000,
        S_A_CHK  = 11'b000_1000_0000,
        S_A_FREE = 11'b001_0000_0000,
        S_A_APP  = 11'b010_0000_0000,
        S_FINISH = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // list and pool pointers, counters
    logic [SW-1:0]    head_reg, head_next;
    logic [SW-1:0]    tail_reg, tail_next;
    logic [SW-1:0]    pool_reg, pool_next;     // head of the chain of reused slots
    logic [SW-1:0]    fresh_reg, fresh_next;   // slots never handed out yet
    logic [SW-1:0]    len_reg, len_next;       // blocks on the free list
    logic [OFF_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] live_reg, live_next;

    // walk registers
    logic [SW-1:0]    cur_reg, cur_next;
    logic [SW-1:0]    prev_reg, prev_next;
    logic [ENT_W-1:0] prev_ent_reg, prev_ent_next;
    logic [SW-1:0]    slot_reg, slot_next;

    // latched item
    logic             mode_reg;
    logic [OFF_W-1:0] foff_reg;
    logic [SIZE_W-1:0] fsize_reg;
    logic [SIZE_W-1:0] req_reg;

    // result under construction
    ffa_pkg::status_t res_stat_reg, res_stat_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;
    logic [SIZE_W-1:0] res_pad_reg, res_pad_next;

    // output register
    logic         m_tvalid_reg;
    logic [103:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    // node table port
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic [ENT_W-1:0] rd_data;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic [OFF_W-1:0]  rd_off;
    logic [SIZE_W-1:0] rd_size;
    logic [SW-1:0]     rd_link;
    logic              out_free;
    logic              cfg_fire;

    assign rd_off  = rd_data[OFF_W-1:0];
    assign rd_size = rd_data[OFF_W+SIZE_W-1:OFF_W];
    assign rd_link = rd_data[ENT_W-1:OFF_W+SIZE_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !m_tvalid_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_tvalid_reg || m_tready;

    ffa_node_store #(
        .DEPTH  (FREE_SLOTS),
        .ADDR_W (IW),
        .LINK_W (SW)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // saturating increment of the live record count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // sequencer
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        pool_next     = pool_reg;
        fresh_next    = fresh_reg;
        len_next      = len_reg;
        end_next      = end_reg;
        live_next     = live_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        prev_ent_next = prev_ent_reg;
        slot_next     = slot_reg;
        res_stat_next = res_stat_reg;
        res_off_next  = res_off_reg;
        res_size_next = res_size_reg;
        res_pad_next  = res_pad_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser ? S_A_STRT : S_LOAD;
                end
            end
            S_LOAD: begin
                res_off_next  = foff_reg;
                res_size_next = fsize_reg;
                res_pad_next  = '0;
                if (len_reg == NONE) begin
                    res_stat_next = ffa_pkg::ST_FULL;
                    state_next    = S_FINISH;
                end else if (fresh_reg != NONE) begin
                    slot_next  = fresh_reg;
                    fresh_next = fresh_reg + 1'b1;
                    state_next = S_L_TAIL;
                end else begin
                    slot_next  = pool_reg;
                    rd_en      = 1'b1;
                    rd_addr    = pool_reg[IW-1:0];
                    state_next = S_L_POP;
                end
            end
            S_L_POP: begin
                pool_next  = rd_link;
                state_next = S_L_TAIL;
            end
            S_L_TAIL: begin
                if (tail_reg != NONE) begin
                    rd_en      = 1'b1;
                    rd_addr    = tail_reg[IW-1:0];
                    state_next = S_L_TWR;
                end else begin
                    head_next  = slot_reg;
                    state_next = S_L_NEW;
                end
            end
            S_L_TWR: begin
                // link the old tail to the new slot
                wr_en      = 1'b1;
                wr_addr    = tail_reg[IW-1:0];
                wr_data    = {slot_reg, rd_size, rd_off};
                state_next = S_L_NEW;
            end
            S_L_NEW: begin
                wr_en         = 1'b1;
                wr_addr       = slot_reg[IW-1:0];
                wr_data       = {NONE, fsize_reg, foff_reg};
                tail_next     = slot_reg;
                len_next      = len_reg + 1'b1;
                res_stat_next = ffa_pkg::ST_LOADED;
                state_next    = S_FINISH;
            end
            S_A_STRT: begin
                if (head_reg == NONE) begin
                    state_next = S_A_APP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg[IW-1:0];
                    cur_next   = head_reg;
                    prev_next  = NONE;
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (req_reg <= rd_size) begin
                    // first fit: unlink the current entry
                    res_off_next  = rd_off;
                    res_size_next = rd_size;
                    res_pad_next  = rd_size - req_reg;
                    if (prev_reg != NONE) begin
                        wr_en   = 1'b1;
                        wr_addr = prev_reg[IW-1:0];
                        wr_data = {rd_link, prev_ent_reg[OFF_W+SIZE_W-1:0]};
                    end else begin
                        head_next = rd_link;
                    end
                    if (tail_reg == cur_reg) begin
                        tail_next = prev_reg;
                    end
                    state_next = S_A_FREE;
                end else begin
                    prev_next     = cur_reg;
                    prev_ent_next = rd_data;
                    cur_next      = rd_link;
                    if (rd_link == NONE) begin
                        state_next = S_A_APP;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = rd_link[IW-1:0];
                    end
                end
            end
            S_A_FREE: begin
                // return the slot to the pool chain
                wr_en         = 1'b1;
                wr_addr       = cur_reg[IW-1:0];
                wr_data       = {pool_reg, {(OFF_W+SIZE_W){1'b0}}};
                pool_next     = cur_reg;
                len_next      = len_reg - 1'b1;
                live_next     = sat_inc(live_reg);
                res_stat_next = ffa_pkg::ST_REUSED;
                state_next    = S_FINISH;
            end
            S_A_APP: begin
                res_off_next  = end_reg;
                res_size_next = req_reg;
                res_pad_next  = '0;
                end_next      = end_reg + OFF_W'(req_reg) + PREFIX;
                live_next     = sat_inc(live_reg);
                res_stat_next = ffa_pkg::ST_APPENDED;
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes land in idle time only
        if (cfg_fire) begin
            case (cfg_index)
                ffa_pkg::CFG_START_END_OFFSET:   end_next  = cfg_data[OFF_W-1:0];
                ffa_pkg::CFG_START_RECORD_COUNT: live_next = cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= NONE;
            tail_reg  <= NONE;
            pool_reg  <= NONE;
            fresh_reg <= '0;
            len_reg   <= '0;
            end_reg   <= ffa_pkg::END_OFFSET_RESET;
            live_reg  <= ffa_pkg::LIVE_RESET;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            pool_reg  <= pool_next;
            fresh_reg <= fresh_next;
            len_reg   <= len_next;
            end_reg   <= end_next;
            live_reg  <= live_next;
        end
    end

    // walk and result payload registers
    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_ent_reg <= prev_ent_next;
        slot_reg     <= slot_next;
        res_stat_reg <= res_stat_next;
        res_off_reg  <= res_off_next;
        res_size_reg <= res_size_next;
        res_pad_reg  <= res_pad_next;
        if (s_tvalid && s_tready) begin
            mode_reg  <= s_tuser;
            foff_reg  <= s_tdata[31:0];
            fsize_reg <= s_tdata[47:32];
            req_reg   <= s_tdata[63:48];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_FINISH && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FINISH && out_free) begin
            m_tuser_reg <= res_stat_reg;
            m_tdata_reg <= {7'd0, (head_reg == NONE),
                            {(CNT_W-SW){1'b0}}, len_reg,
                            live_reg, res_pad_reg, res_size_reg, res_off_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // an empty list carries no removed blocks
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[96]) |-> (m_tdata[95:80] == 16'd0))
        else $error("list_empty with nonzero removed_count");

    // filler never exceeds the reused block size
    a_pad_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ffa_pkg::ST_REUSED) |-> (m_tdata[63:48] <= m_tdata[47:32]))
        else $error("pad_bytes larger than slot_size");

    // between items head, tail and length agree on an empty list
    a_idle_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (((head_reg == NONE) == (tail_reg == NONE))
                                   && ((head_reg == NONE) == (len_reg == '0))))
        else $error("free list pointers and length disagree");

    // a mode seen at accept picks the matching branch
    a_branch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD) |-> !mode_reg)
        else $error("load branch entered for an allocate item");

endmodule

### tb/ffa_placement_checker.sv
// ----------------------------------------------------------------------------
// ffa_placement_checker
// Watches the item, result and register channels of the first-fit allocator.
// It keeps its own copy of the free list, predicts each result beat and
// compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
package ffa_stim_pkg;

    // item kinds carried on s_tuser
    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_ALLOC = 1'b1
    } mode_t;

endpackage

module ffa_placement_checker #(
    parameter int FREE_SLOTS   = 64,
    parameter int PREFIX_BYTES = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [31:0] free_offset, [47:32] free_size, [63:48] request_size
    input  logic [63:0]                     s_tdata,
    // [0] mode
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] place_offset, [47:32] slot_size, [63:48] pad_bytes,
    // [79:64] record_count, [95:80] removed_count, [96] list_empty
    input  logic [103:0]                    m_tdata,
    // [1:0] status
    input  logic [1:0]                      m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffa_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              outstanding,
    output int                              n_reused,
    output int                              n_appended,
    output int                              n_loaded,
    output int                              n_full
);

    localparam int OFF_W   = ffa_pkg::OFF_W;
    localparam int SIZE_W  = ffa_pkg::SIZE_W;
    localparam int CNT_W   = ffa_pkg::CNT_W;
    localparam int NO_SLOT = FREE_SLOTS;

    typedef struct packed {
        ffa_pkg::status_t  status;
        logic [OFF_W-1:0]  place_offset;
        logic [SIZE_W-1:0] slot_size;
        logic [SIZE_W-1:0] pad_bytes;
        logic [CNT_W-1:0]  record_count;
        logic [CNT_W-1:0]  removed_count;
        logic              list_empty;
    } placement_t;

    // mirror of the free list and the counters
    logic [OFF_W-1:0]  blk_offset [FREE_SLOTS];
    logic [SIZE_W-1:0] blk_size   [FREE_SLOTS];
    int                blk_next   [FREE_SLOTS];
    bit                slot_busy  [FREE_SLOTS];
    int                list_head;
    int                list_tail;
    logic [OFF_W-1:0]  end_offset;
    logic [CNT_W-1:0]  live_count;
    logic [CNT_W-1:0]  freed_count;

    placement_t        expected_placements [$];
    int                mismatches;
    int                seen_status [4];

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // result beat built from the counters after the update
    function automatic placement_t make_placement(ffa_pkg::status_t st,
                                                  logic [OFF_W-1:0] off,
                                                  logic [SIZE_W-1:0] sz,
                                                  logic [SIZE_W-1:0] pad);
        placement_t r;
        r.status        = st;
        r.place_offset  = off;
        r.slot_size     = sz;
        r.pad_bytes     = pad;
        r.record_count  = live_count;
        r.removed_count = freed_count;
        r.list_empty    = (list_head == NO_SLOT);
        return r;
    endfunction

    // load a freed block or place a record, first fit, else at the end offset
    task automatic place_record(input ffa_stim_pkg::mode_t mode,
                                input logic [OFF_W-1:0] foff,
                                input logic [SIZE_W-1:0] fsize,
                                input logic [SIZE_W-1:0] req,
                                output placement_t r);
        int slot;
        int prev;
        int cur;
        int i;
        bit hit;
        slot = NO_SLOT;
        prev = NO_SLOT;
        cur  = list_head;
        hit  = 1'b0;
        if (mode == ffa_stim_pkg::MODE_LOAD) begin
            for (i = FREE_SLOTS - 1; i >= 0; i--) begin
                if (!slot_busy[i]) slot = i;
            end
            if (slot == NO_SLOT) begin
                r = make_placement(ffa_pkg::ST_FULL, foff, fsize, '0);
            end else begin
                blk_offset[slot] = foff;
                blk_size[slot]   = fsize;
                blk_next[slot]   = NO_SLOT;
                slot_busy[slot]  = 1'b1;
                if (list_tail != NO_SLOT) blk_next[list_tail] = slot;
                else list_head = slot;
                list_tail   = slot;
                freed_count = sat_inc(freed_count);
                r = make_placement(ffa_pkg::ST_LOADED, foff, fsize, '0);
            end
        end else begin
            for (i = 0; i < FREE_SLOTS && cur != NO_SLOT && !hit; i++) begin
                if (req <= blk_size[cur]) begin
                    hit = 1'b1;
                end else begin
                    prev = cur;
                    cur  = blk_next[cur];
                end
            end
            if (hit) begin
                if (prev != NO_SLOT) blk_next[prev] = blk_next[cur];
                else list_head = blk_next[cur];
                if (list_tail == cur) list_tail = prev;
                slot_busy[cur] = 1'b0;
                live_count = sat_inc(live_count);
                if (freed_count != 0) freed_count = freed_count - 1'b1;
                r = make_placement(ffa_pkg::ST_REUSED, blk_offset[cur], blk_size[cur],
                                   blk_size[cur] - req);
            end else begin
                r = make_placement(ffa_pkg::ST_APPENDED, end_offset, req, '0);
                end_offset = end_offset + OFF_W'(req) + OFF_W'(PREFIX_BYTES);
                live_count = sat_inc(live_count);
                r.record_count = live_count;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [OFF_W-1:0] want,
                               input logic [OFF_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    initial begin
        mismatches = 0;
        for (int k = 0; k < 4; k++) seen_status[k] = 0;
    end

    // beat monitor: register writes, result compare, then new predictions
    always @(posedge aclk) begin : monitor
        placement_t want;
        int k;
        if (!aresetn) begin
            for (k = 0; k < FREE_SLOTS; k++) begin
                slot_busy[k]  = 1'b0;
                blk_offset[k] = '0;
                blk_size[k]   = '0;
                blk_next[k]   = NO_SLOT;
            end
            list_head   = NO_SLOT;
            list_tail   = NO_SLOT;
            end_offset  = ffa_pkg::END_OFFSET_RESET;
            live_count  = ffa_pkg::LIVE_RESET;
            freed_count = '0;
            expected_placements.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ffa_pkg::CFG_START_END_OFFSET)
                    end_offset = cfg_data;
                else if (cfg_index == ffa_pkg::CFG_START_RECORD_COUNT)
                    live_count = cfg_data[CNT_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                seen_status[m_tuser]++;
                if (expected_placements.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, got status %0d data 0x%0h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = expected_placements.pop_front();
                    check_field("status", OFF_W'(want.status), OFF_W'(m_tuser));
                    check_field("place_offset", want.place_offset, m_tdata[31:0]);
                    check_field("slot_size", OFF_W'(want.slot_size), OFF_W'(m_tdata[47:32]));
                    check_field("pad_bytes", OFF_W'(want.pad_bytes), OFF_W'(m_tdata[63:48]));
                    check_field("record_count", OFF_W'(want.record_count),
                                OFF_W'(m_tdata[79:64]));
                    check_field("removed_count", OFF_W'(want.removed_count),
                                OFF_W'(m_tdata[95:80]));
                    check_field("list_empty", OFF_W'(want.list_empty), OFF_W'(m_tdata[96]));
                end
            end
            if (s_tvalid && s_tready) begin
                place_record(ffa_stim_pkg::mode_t'(s_tuser), s_tdata[31:0], s_tdata[47:32],
                             s_tdata[63:48], want);
                expected_placements.push_back(want);
            end
        end
        fail_count  <= mismatches;
        outstanding <= expected_placements.size();
        n_reused    <= seen_status[ffa_pkg::ST_REUSED];
        n_appended  <= seen_status[ffa_pkg::ST_APPENDED];
        n_loaded    <= seen_status[ffa_pkg::ST_LOADED];
        n_full      <= seen_status[ffa_pkg::ST_FULL];
    end

endmodule

### tb/first_fit_free_list_allocator_core_test.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core_test
// Drives loads and allocations into the allocator: a directed opening on
// list edges, wrap and saturation, then three random phases with table-fill
// bursts and long no-fit walks under varying stalls on both sides.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core_test;

    localparam int OFF_W        = ffa_pkg::OFF_W;
    localparam int SIZE_W       = ffa_pkg::SIZE_W;
    localparam int CFG_IDX_W    = ffa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = ffa_pkg::CFG_DATA_W;
    localparam int FREE_SLOTS   = 64;
    localparam int PREFIX_BYTES = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = FREE_SLOTS + 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hA5;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [103:0]          m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int n_reused;
    int n_appended;
    int n_loaded;
    int n_full;
    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;
    int cycle_count = 0;

    always #4 aclk = ~aclk;

    first_fit_free_list_allocator_core #(
        .FREE_SLOTS   (FREE_SLOTS),
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ffa_placement_checker #(
        .FREE_SLOTS   (FREE_SLOTS),
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .n_reused    (n_reused),
        .n_appended  (n_appended),
        .n_loaded    (n_loaded),
        .n_full      (n_full)
    );

    // result-side backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one item beat, with random sender gaps ahead of it
    task automatic send_item(input ffa_stim_pkg::mode_t mode,
                             input logic [OFF_W-1:0] foff,
                             input logic [SIZE_W-1:0] fsize,
                             input logic [SIZE_W-1:0] req);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {req, fsize, foff};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // sender holds off until every expected result has come back
    task automatic wait_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly small sizes so fits happen; now and then the full 16-bit range
    function automatic logic [SIZE_W-1:0] pick_size();
        if ($urandom_range(0, 7) == 0) return SIZE_W'($urandom_range(0, 65535));
        return SIZE_W'($urandom_range(0, 600));
    endfunction

    task automatic send_random_item();
        ffa_stim_pkg::mode_t mode;
        mode = ($urandom_range(0, 99) < 52) ? ffa_stim_pkg::MODE_LOAD
                                            : ffa_stim_pkg::MODE_ALLOC;
        if ($urandom_range(0, 39) == 0) wait_until_drained();
        send_item(mode, $urandom, pick_size(), pick_size());
    endtask

    // fill the table past full, walk it with no fit, then take a few blocks
    task automatic fill_table();
        repeat (68) send_item(ffa_stim_pkg::MODE_LOAD, $urandom,
                              SIZE_W'($urandom_range(0, 1000)), pick_size());
        repeat (6) send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, pick_size(),
                             SIZE_W'($urandom_range(1001, 65535)));
        repeat (8) send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, pick_size(),
                             SIZE_W'($urandom_range(0, 1000)));
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct,
                             input logic [CFG_DATA_W-1:0] start_offset,
                             input logic [CFG_DATA_W-1:0] start_count);
        wait_until_drained();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_register(ffa_pkg::CFG_START_END_OFFSET, start_offset);
        write_register(ffa_pkg::CFG_START_RECORD_COUNT, start_count);
        repeat (60) send_random_item();
        fill_table();
        repeat (53) send_random_item();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ffa_stim_pkg::MODE_LOAD;
        cfg_valid   = 1'b0;
        cfg_index   = ffa_pkg::CFG_START_END_OFFSET;
        cfg_data    = '0;
        tx_idle_pct = 10;
        rx_idle_pct = 61;
        items_sent  = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty list, head/middle/tail unlink, exact and no fit
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, 16'hFFFF, 16'h0000);
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, 16'h0000, 16'hFFFF);
        send_item(ffa_stim_pkg::MODE_LOAD, 32'h0000_0000, 16'h0000, 16'hFFFF);
        send_item(ffa_stim_pkg::MODE_LOAD, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        send_item(ffa_stim_pkg::MODE_LOAD, 32'h0000_1000, 16'd100, SIZE_W'($urandom));
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd50);
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd0);
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd100);
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd200);
        send_item(ffa_stim_pkg::MODE_LOAD, 32'hAAAA_5555, 16'd7, SIZE_W'($urandom));
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd8);
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd7);

        // end offset wraps, live count saturates, unmapped index is dropped
        wait_until_drained();
        write_register(ffa_pkg::CFG_START_END_OFFSET, 32'hFFFF_FFFC);
        write_register(ffa_pkg::CFG_START_RECORD_COUNT, 32'h0000_FFFE);
        write_register(CFG_UNMAPPED, 32'h1234_5678);
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd10);
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd3);
        send_item(ffa_stim_pkg::MODE_LOAD, 32'h5555_AAAA, 16'd40, SIZE_W'($urandom));
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd40);

        wait_until_drained();
        write_register(ffa_pkg::CFG_START_END_OFFSET, 32'h0000_0000);
        write_register(ffa_pkg::CFG_START_RECORD_COUNT, 32'h0000_0000);
        send_item(ffa_stim_pkg::MODE_ALLOC, $urandom, SIZE_W'($urandom), 16'd0);

        // random phases: sender light / receiver heavy, swapped, then none
        run_phase(10, 61, $urandom, $urandom_range(0, 100));
        run_phase(61, 10, 32'hFFFF_FF00, 32'h0000_FFF0);
        run_phase(0, 0, 32'hFFFF_FFFF, 32'h0000_0000);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items: %0d reused, %0d appended, %0d loaded, %0d table-full beats",
                 items_sent, n_reused, n_appended, n_loaded, n_full);
        $display("Register writes exercised offset wrap, count saturation and an unknown index");
        if (fail_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
